// ===== sv/hlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlbc_pkg: shared constants for the biquad cascade
// Widths, register indexes and the accumulator size.
// ----------------------------------------------------------------------------
package hlbc_pkg;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int CHANNELS    = 8;
  localparam int CH_BITS     = 3;
  localparam int HIST_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Two times b0 needs one extra bit; negated coefficients need one more.
  localparam int MC_BITS     = COEF_BITS + 2;
  localparam int PROD_BITS   = MC_BITS + SAMPLE_BITS;
  localparam int ACC_BITS    = PROD_BITS + 4;
  localparam int SH_BITS     = $clog2(SAMPLE_BITS + 1);

  localparam logic [2:0] REG_HPF_EN = 3'd0;
  localparam logic [2:0] REG_HPF_B0 = 3'd1;
  localparam logic [2:0] REG_HPF_A1 = 3'd2;
  localparam logic [2:0] REG_HPF_A2 = 3'd3;
  localparam logic [2:0] REG_LPF_EN = 3'd4;
  localparam logic [2:0] REG_LPF_B0 = 3'd5;
  localparam logic [2:0] REG_LPF_A1 = 3'd6;
  localparam logic [2:0] REG_LPF_A2 = 3'd7;

  typedef struct packed {
    logic start;
  } mac_ctl_t;
endpackage

// ===== sv/hlbc_mac.sv =====
// ----------------------------------------------------------------------------
// hlbc_mac: bit-serial multiplier
// Shift-add product of a coefficient and a sample, one sample bit a cycle.
// ----------------------------------------------------------------------------
module hlbc_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  hlbc_pkg::mac_ctl_t                     ctl_i,
  input  logic signed [hlbc_pkg::MC_BITS-1:0]    coef,
  input  logic signed [hlbc_pkg::SAMPLE_BITS-1:0] smp,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [hlbc_pkg::PROD_BITS-1:0]  prod
);
  logic signed [hlbc_pkg::PROD_BITS-1:0] mc_r, prod_r;
  logic [hlbc_pkg::SAMPLE_BITS-1:0] sr_r;
  logic [hlbc_pkg::SH_BITS-1:0] cnt_r;
  logic busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mc_r   <= hlbc_pkg::PROD_BITS'(coef);
        sr_r   <= smp;
        prod_r <= '0;
      end else if (busy_r) begin
        // Top sample bit carries negative weight.
        if (sr_r[0]) begin
          if (cnt_r == hlbc_pkg::SH_BITS'(hlbc_pkg::SAMPLE_BITS - 1))
            prod_r <= prod_r - mc_r;
          else
            prod_r <= prod_r + mc_r;
        end
        mc_r <= mc_r <<< 1;
        sr_r <= sr_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == hlbc_pkg::SH_BITS'(hlbc_pkg::SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = prod_r;
endmodule

// ===== sv/hpf_lpf_biquad_cascade_unit.sv =====
// ----------------------------------------------------------------------------
// hpf_lpf_biquad_cascade_unit: highpass then lowpass biquad per channel
// Per enabled stage: a load step, five multiply-accumulates on the bit-serial
// multiplier in turn, and a finish step that writes the history. A new beat is
// taken only when idle, after the last result has been taken, so throughput is
// set by the bit-serial multiplier that runs the products in turn.
// Reset clears config and state registers, then the history of all channels.
// ----------------------------------------------------------------------------
module hpf_lpf_biquad_cascade_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [2:0]                              cfg_index,
  input  logic [31:0]                             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [hlbc_pkg::CH_BITS-1:0]            in_channel,
  input  logic signed [hlbc_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [hlbc_pkg::CH_BITS-1:0]            out_channel_out,
  output logic signed [hlbc_pkg::SAMPLE_BITS-1:0] out_sample_out
);
  localparam int SB = hlbc_pkg::SAMPLE_BITS;
  localparam int MB = hlbc_pkg::MC_BITS;
  localparam int AB = hlbc_pkg::ACC_BITS;
  localparam int HB = hlbc_pkg::HIST_BITS;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_LOAD, S_MUL, S_WAIT, S_FIN, S_OUT} st_t;
  st_t st_r;

  logic hen_r, len_r;
  logic signed [31:0] hb0_r, ha1_r, ha2_r, lb0_r, la1_r, la2_r;
  logic signed [SB-1:0] hh_r [4][hlbc_pkg::CHANNELS];
  logic signed [SB-1:0] lh_r [4][hlbc_pkg::CHANNELS];
  logic [HB-1:0] clr_r, chi_r;
  logic [hlbc_pkg::CH_BITS-1:0] ch_r;
  logic signed [SB-1:0] x_r, tap_r [4];
  logic stg_r;
  logic [2:0] term_r;
  logic signed [AB-1:0] acc_r;
  logic signed [MB-1:0] coef;
  logic signed [SB-1:0] smp;
  hlbc_pkg::mac_ctl_t mctl;
  logic mbusy, mdone;
  logic signed [hlbc_pkg::PROD_BITS-1:0] prod;
  logic signed [AB-1:0] rnd;
  logic signed [AB-31:0] shv;
  logic signed [SB-1:0] y;

  always_comb begin
    logic signed [MB-1:0] b0, a1, a2;
    b0 = stg_r ? MB'(lb0_r) : MB'(hb0_r);
    a1 = stg_r ? MB'(la1_r) : MB'(ha1_r);
    a2 = stg_r ? MB'(la2_r) : MB'(ha2_r);
    case (term_r)
      3'd0: begin coef = b0; smp = x_r; end
      3'd1: begin coef = stg_r ? (b0 <<< 1) : -(b0 <<< 1); smp = tap_r[0]; end
      3'd2: begin coef = b0; smp = tap_r[1]; end
      3'd3: begin coef = -a1; smp = tap_r[2]; end
      default: begin coef = -a2; smp = tap_r[3]; end
    endcase
  end

  assign mctl.start = (st_r == S_MUL);

  hlbc_mac u_mac (.clk(clk), .rst_n(rst_n), .ctl_i(mctl), .coef(coef), .smp(smp),
    .busy(mbusy), .done(mdone), .prod(prod));

  assign rnd = acc_r + (AB'(1) <<< 29);
  assign shv = rnd[AB-1:30];
  always_comb begin
    if (shv > (AB-30)'((1 << (SB-1)) - 1)) y = SB'((1 << (SB-1)) - 1);
    else if (shv < -(AB-30)'(1 << (SB-1))) y = SB'(-(1 << (SB-1)));
    else y = shv[SB-1:0];
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_channel_out = ch_r;
  assign out_sample_out = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0;
      hen_r <= 1'b0; len_r <= 1'b0;
      hb0_r <= '0; ha1_r <= '0; ha2_r <= '0;
      lb0_r <= '0; la1_r <= '0; la2_r <= '0;
      stg_r <= 1'b0; term_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hlbc_pkg::REG_HPF_EN: hen_r <= cfg_data[0];
          hlbc_pkg::REG_HPF_B0: hb0_r <= cfg_data;
          hlbc_pkg::REG_HPF_A1: ha1_r <= cfg_data;
          hlbc_pkg::REG_HPF_A2: ha2_r <= cfg_data;
          hlbc_pkg::REG_LPF_EN: len_r <= cfg_data[0];
          hlbc_pkg::REG_LPF_B0: lb0_r <= cfg_data;
          hlbc_pkg::REG_LPF_A1: la1_r <= cfg_data;
          hlbc_pkg::REG_LPF_A2: la2_r <= cfg_data;
          default: ;
        endcase
      end
      case (st_r)
        S_CLR: begin
          for (int k = 0; k < 4; k++) begin
            hh_r[k][clr_r] <= '0;
            lh_r[k][clr_r] <= '0;
          end
          clr_r <= clr_r + 1'b1;
          if (clr_r == HB'(hlbc_pkg::CHANNELS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          ch_r <= in_channel; x_r <= in_sample_in;
          chi_r <= HB'(in_channel);
          stg_r <= 1'b0;
          if (32'(in_channel) >= hlbc_pkg::CHANNELS) st_r <= S_OUT;
          else if (hen_r) st_r <= S_LOAD;
          else if (len_r) begin stg_r <= 1'b1; st_r <= S_LOAD; end
          else st_r <= S_OUT;
        end
        S_LOAD: begin
          for (int k = 0; k < 4; k++)
            tap_r[k] <= stg_r ? lh_r[k][chi_r] : hh_r[k][chi_r];
          acc_r <= '0; term_r <= '0; st_r <= S_MUL;
        end
        S_MUL: st_r <= S_WAIT;
        S_WAIT: if (mdone) begin
          acc_r <= acc_r + AB'(prod);
          if (term_r == 3'd4) st_r <= S_FIN;
          else begin term_r <= term_r + 1'b1; st_r <= S_MUL; end
        end
        S_FIN: begin
          if (stg_r) begin
            lh_r[0][chi_r] <= x_r; lh_r[1][chi_r] <= tap_r[0];
            lh_r[2][chi_r] <= y;   lh_r[3][chi_r] <= tap_r[2];
          end else begin
            hh_r[0][chi_r] <= x_r; hh_r[1][chi_r] <= tap_r[0];
            hh_r[2][chi_r] <= y;   hh_r[3][chi_r] <= tap_r[2];
          end
          x_r <= y;
          if (!stg_r && len_r) begin stg_r <= 1'b1; st_r <= S_LOAD; end
          else st_r <= S_OUT;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) |-> !mbusy) else $error("multiplier restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)))
    else $error("result dropped");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accepting while holding result");
`endif
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for hpf_lpf_biquad_cascade_unit
// A directed table followed by random phases under changing coefficients and
// flow control. Beats are checked against a bit-exact model or typed rows.
// ----------------------------------------------------------------------------
module testbench;
  localparam int    RAND_PHASES = 8;
  localparam int    PHASE_BEATS = 100;
  localparam int    DRAIN_WAIT  = 600;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef logic signed [hlbc_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef logic [hlbc_pkg::CH_BITS-1:0]            chan_t;

  typedef struct {
    chan_t   ch;
    sample_t s;
  } beat_t;

  typedef struct {
    chan_t   ch;
    sample_t s;
    bit      typed;
    sample_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [2:0]             cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  chan_t                  in_channel = '0;
  sample_t                in_sample_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  chan_t                  out_channel_out;
  sample_t                out_sample_out;

  hpf_lpf_biquad_cascade_unit dut (.*);

  always #2 clk = ~clk;

  // Filter model state.
  bit             hp_on, lp_on;
  longint         hp_b0, hp_a1, hp_a2, lp_b0, lp_a1, lp_a2;
  sample_t        hp_hist [hlbc_pkg::CHANNELS][4];
  sample_t        lp_hist [hlbc_pkg::CHANNELS][4];

  beat_t          pending_out [$];
  sample_t        typed_want [$];
  bit             typed_flag [$];
  int             errors = 0;
  int             send_idle = 0;
  int             recv_stall = 0;
  longint         cycles = 0;

  function automatic sample_t biquad(input bit lowpass, input int ch, input sample_t x);
    longint b0, b1, a1, a2, acc, y;
    sample_t h [4];
    sample_t r;
    b0 = lowpass ? lp_b0 : hp_b0;
    a1 = lowpass ? lp_a1 : hp_a1;
    a2 = lowpass ? lp_a2 : hp_a2;
    b1 = lowpass ? 2 * b0 : -2 * b0;
    if (lowpass) h = lp_hist[ch];
    else h = hp_hist[ch];
    acc = b0 * longint'(x) + b1 * longint'(h[0]) + b0 * longint'(h[1])
        - a1 * longint'(h[2]) - a2 * longint'(h[3]);
    y = (acc + (longint'(1) <<< 29)) >>> 30;
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    r = sample_t'(y);
    h[1] = h[0];
    h[0] = x;
    h[3] = h[2];
    h[2] = r;
    if (lowpass) lp_hist[ch] = h;
    else hp_hist[ch] = h;
    return r;
  endfunction

  function automatic sample_t filter_beat(input chan_t ch, input sample_t x);
    sample_t v;
    v = x;
    if (int'(ch) < hlbc_pkg::CHANNELS) begin
      if (hp_on) v = biquad(1'b0, int'(ch), v);
      if (lp_on) v = biquad(1'b1, int'(ch), v);
    end
    return v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      hlbc_pkg::REG_HPF_EN: hp_on = val[0];
      hlbc_pkg::REG_HPF_B0: hp_b0 = longint'($signed(val));
      hlbc_pkg::REG_HPF_A1: hp_a1 = longint'($signed(val));
      hlbc_pkg::REG_HPF_A2: hp_a2 = longint'($signed(val));
      hlbc_pkg::REG_LPF_EN: lp_on = val[0];
      hlbc_pkg::REG_LPF_B0: lp_b0 = longint'($signed(val));
      hlbc_pkg::REG_LPF_A1: lp_a1 = longint'($signed(val));
      hlbc_pkg::REG_LPF_A2: lp_a2 = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_coefs(input bit he, input logic [31:0] hb, ha1, ha2,
                            input bit le, input logic [31:0] lb, la1, la2);
    write_reg(hlbc_pkg::REG_HPF_EN, {31'd0, he});
    write_reg(hlbc_pkg::REG_HPF_B0, hb);
    write_reg(hlbc_pkg::REG_HPF_A1, ha1);
    write_reg(hlbc_pkg::REG_HPF_A2, ha2);
    write_reg(hlbc_pkg::REG_LPF_EN, {31'd0, le});
    write_reg(hlbc_pkg::REG_LPF_B0, lb);
    write_reg(hlbc_pkg::REG_LPF_A1, la1);
    write_reg(hlbc_pkg::REG_LPF_A2, la2);
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(input chan_t ch, input sample_t s, input bit typed,
                           input sample_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_sample_in <= s;
    typed_flag.push_back(typed);
    typed_want.push_back(want);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef;
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(32'h7fffffff) >> 2)) * ($urandom_range(1) ? 1 : -1);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(32'h00ffffff))) - 32'sh00800000;
    endcase
  endfunction

  function automatic sample_t rand_sample;
    case ($urandom_range(4))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return sample_t'($signed($urandom_range(2047)) - 1024);
      default: return sample_t'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    beat_t b;
    bit t;
    sample_t w;
    if (rst_n && in_valid && in_ready) begin
      t = typed_flag.pop_front();
      w = typed_want.pop_front();
      b.ch = in_channel;
      b.s  = filter_beat(in_channel, in_sample_in);
      if (t) b.s = w;
      pending_out.push_back(b);
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $error("result beat with nothing expected: channel %0d sample %0d",
               out_channel_out, out_sample_out);
        errors++;
      end else begin
        e = pending_out.pop_front();
        if (out_channel_out !== e.ch) begin
          $error("channel_out: expected %0d, actual %0d", e.ch, out_channel_out);
          errors++;
        end
        if (out_sample_out !== e.s) begin
          $error("sample_out: expected %0d, actual %0d", e.s, out_sample_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hpf_lpf_biquad_cascade_unit regression: fail");
      $finish;
    end
  end

  row_t rows [] = '{
    '{3'd0, 24'h7fffff, 1'b1, 24'h7fffff},
    '{3'd7, 24'h800000, 1'b1, 24'h800000},
    '{3'd3, 24'h000000, 1'b1, 24'h000000},
    '{3'd5, 24'hffffff, 1'b1, 24'hffffff},
    '{3'd1, 24'h555555, 1'b1, 24'h555555},
    '{3'd6, 24'haaaaaa, 1'b1, 24'haaaaaa},
    '{3'd2, 24'h7fffff, 1'b0, 24'h0},
    '{3'd2, 24'h800000, 1'b0, 24'h0},
    '{3'd2, 24'h7fffff, 1'b0, 24'h0},
    '{3'd2, 24'h800000, 1'b0, 24'h0},
    '{3'd4, 24'h000001, 1'b0, 24'h0},
    '{3'd4, 24'h000000, 1'b0, 24'h0},
    '{3'd4, 24'h000000, 1'b0, 24'h0},
    '{3'd0, 24'h7fffff, 1'b0, 24'h0},
    '{3'd7, 24'h800000, 1'b0, 24'h0},
    '{3'd7, 24'h123456, 1'b0, 24'h0}
  };

  initial begin
    int mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (10) @(posedge clk);

    // After reset both stages are bypassed, so samples come back unchanged.
    foreach (rows[i]) begin
      if (i == 6) begin
        drain();
        load_coefs(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000);
      end
      if (i == 11) begin
        drain();
        load_coefs(1'b1, 32'h40000000, 32'h00000000, 32'h00000000,
                   1'b1, 32'h10000000, 32'h00000000, 32'h00000000);
      end
      send_beat(rows[i].ch, rows[i].s, rows[i].typed, rows[i].want);
    end
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = p % 4;
      send_idle  = (mode == 1) ? 69 : (mode == 3) ? 29 : 0;
      recv_stall = (mode == 2) ? 69 : (mode == 3) ? 29 : 0;
      if (p % 3 == 0)
        load_coefs(1'b1, 32'h3a000000, 32'h88000000, 32'h30000000,
                   1'b1, 32'h01000000, 32'h88000000, 32'h30000000);
      else
        load_coefs(1'($urandom_range(1)), rand_coef(), rand_coef(), rand_coef(),
                   1'($urandom_range(1)), rand_coef(), rand_coef(), rand_coef());
      for (int n = 0; n < PHASE_BEATS; n++)
        send_beat(chan_t'($urandom_range(hlbc_pkg::CHANNELS - 1)), rand_sample(),
                  1'b0, 24'h0);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_out.size() == 0)
      $display("hpf_lpf_biquad_cascade_unit regression: pass");
    else
      $display("hpf_lpf_biquad_cascade_unit regression: fail");
    $finish;
  end
endmodule
